// ----- sv/cfft_pkg.sv -----
package cfft_pkg;

	// Counter and index widths of the internal state
	localparam int COUNT_BITS = 16;
	localparam int INDEX_BITS = 8;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

	// Byte classes reported in byte_kind
	typedef enum logic [2:0] {
		KIND_DIGIT   = 3'd0,
		KIND_COLON   = 3'd1,
		KIND_CONTENT = 3'd2,
		KIND_SEP     = 3'd3,
		KIND_END     = 3'd4,
		KIND_CLEAR   = 3'd5
	} kind_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_FIELD_SEPARATOR  = 1'b0,
		REG_FRAME_TERMINATOR = 1'b1
	} reg_idx_t;

	localparam logic [7:0] SEP_RESET  = 8'd59; // ';'
	localparam logic [7:0] TERM_RESET = 8'd10; // '\n'
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

endpackage

// ----- sv/cfft_if.sv -----
// Input request channel: one received byte or a clear
interface cfft_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       clear_frame;

	modport source (output valid, output data_byte, output clear_frame, input ready);
	modport sink (input valid, input data_byte, input clear_frame, output ready);
endinterface

// Output request channel: classification of one byte
interface cfft_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [2:0]  byte_kind;
	logic [7:0]  field_index;
	logic [15:0] leading_value;
	logic [15:0] field_length;
	logic        overflow_flag;

	modport source (output valid, output out_byte, output byte_kind, output field_index,
		output leading_value, output field_length, output overflow_flag, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input field_index,
		input leading_value, input field_length, input overflow_flag, output ready);
endinterface

// ----- sv/counted_field_frame_tokenizer_unit.sv -----
// Channel    Dir  Handshake      Payload
// in_ch      in   valid/ready    data_byte[7:0], clear_frame
// out_ch     out  valid/ready    out_byte, byte_kind, field_index, leading_value,
//                                field_length, overflow_flag
// cfg        in   cfg_wen        cfg_index (0 separator, 1 terminator), cfg_wdata[7:0]
//
// One request per cycle while the output is not stalled; its result is held in the output register in the next cycle.
// The result is computed combinationally by the single per-byte state update feeding that register.
// in_ch.ready is high whenever the output register is empty or being drained, so a
// stalled output holds the result and stops intake until it is taken.
// arst_n clears the parser state, the output valid and restores ';' and '\n'.
module counted_field_frame_tokenizer_unit (
	input  logic              clk,
	input  logic              arst_n,
	cfft_in_if.sink           in_ch,
	cfft_out_if.source        out_ch,
	input  logic              cfg_wen,
	input  logic [0:0]        cfg_index,
	input  logic [7:0]        cfg_wdata
);

	typedef enum logic [2:0] {
		MODE_START,
		MODE_DIGITS,
		MODE_PLAIN,
		MODE_COUNTED,
		MODE_AFTER
	} mode_t;

	localparam int CB = cfft_pkg::COUNT_BITS;
	localparam int IB = cfft_pkg::INDEX_BITS;

	// configuration
	logic [7:0] sep_q, term_q;

	// parser state
	mode_t          mode_q;
	logic [CB-1:0]  dval_q;
	logic [CB-1:0]  brem_q;
	logic [IB-1:0]  cfield_q;
	logic [CB-1:0]  ccount_q;
	logic           sat_q;

	// next state
	mode_t          mode_n;
	logic [CB-1:0]  dval_n;
	logic [CB-1:0]  brem_n;
	logic [IB-1:0]  cfield_n;
	logic [CB-1:0]  ccount_n;
	logic           sat_n;

	// result of this byte, before the field is closed
	cfft_pkg::kind_t kind;
	logic [CB-1:0]   res_val;
	logic [CB-1:0]   res_len;
	logic            res_ovf;

	logic            is_digit;
	logic [CB+3:0]   dval_x10;   // value*10 + digit, room for the carry out
	logic [CB-1:0]   ccount_inc;
	logic            ccount_full;

	// output register
	logic        out_valid_q;
	logic [7:0]  obyte_q;
	logic [2:0]  okind_q;
	logic [7:0]  oidx_q;
	logic [15:0] oval_q;
	logic [15:0] olen_q;
	logic        oovf_q;

	logic in_acc;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;

	assign is_digit    = in_ch.data_byte inside {[cfft_pkg::CHAR_ZERO:cfft_pkg::CHAR_NINE]};
	assign dval_x10    = ({4'b0, dval_q} << 3) + ({4'b0, dval_q} << 1) +
	                     (CB+4)'(in_ch.data_byte - cfft_pkg::CHAR_ZERO);
	assign ccount_full = (ccount_q == cfft_pkg::COUNT_MAX);
	assign ccount_inc  = ccount_full ? ccount_q : ccount_q + 1'b1;

	always_comb begin
		mode_n   = mode_q;
		dval_n   = dval_q;
		brem_n   = brem_q;
		cfield_n = cfield_q;
		ccount_n = ccount_q;
		sat_n    = sat_q;
		kind     = cfft_pkg::KIND_CONTENT;

		if (mode_q == MODE_COUNTED) begin
			// counted run: every byte is content, whatever its value
			ccount_n = ccount_inc;
			sat_n    = sat_q | ccount_full;
			brem_n   = (brem_q != '0) ? brem_q - 1'b1 : brem_q;
			if (brem_n == '0) begin
				mode_n = MODE_AFTER;
			end
			kind = cfft_pkg::KIND_CONTENT;
		end else if (mode_q == MODE_AFTER) begin
			// past counted content: terminator ends, anything else separates
			kind = (in_ch.data_byte == term_q) ? cfft_pkg::KIND_END : cfft_pkg::KIND_SEP;
		end else if ((mode_q inside {MODE_START, MODE_DIGITS}) && is_digit) begin
			if (dval_x10 > (CB+4)'(cfft_pkg::COUNT_MAX)) begin
				dval_n = cfft_pkg::COUNT_MAX;
				sat_n  = 1'b1;
			end else begin
				dval_n = dval_x10[CB-1:0];
			end
			// digits count as content until a colon shows up
			ccount_n = ccount_inc;
			if (ccount_full) begin
				sat_n = 1'b1;
			end
			mode_n = MODE_DIGITS;
			kind   = cfft_pkg::KIND_DIGIT;
		end else if (mode_q == MODE_DIGITS && in_ch.data_byte == cfft_pkg::CHAR_COLON) begin
			ccount_n = '0;
			brem_n   = dval_q;
			mode_n   = (dval_q == '0) ? MODE_AFTER : MODE_COUNTED;
			kind     = cfft_pkg::KIND_COLON;
		end else if (in_ch.data_byte == term_q) begin
			kind = cfft_pkg::KIND_END;
		end else if (in_ch.data_byte == sep_q) begin
			kind = cfft_pkg::KIND_SEP;
		end else begin
			ccount_n = ccount_inc;
			sat_n    = sat_q | ccount_full;
			mode_n   = MODE_PLAIN;
			kind     = cfft_pkg::KIND_CONTENT;
		end

		res_val = dval_n;
		res_len = ccount_n;
		res_ovf = sat_n;

		// close the field after it has been reported
		if (kind inside {cfft_pkg::KIND_END, cfft_pkg::KIND_SEP}) begin
			if (kind == cfft_pkg::KIND_END) begin
				cfield_n = '0;
			end else if (cfield_q != cfft_pkg::INDEX_MAX) begin
				cfield_n = cfield_q + 1'b1;
			end
			mode_n   = MODE_START;
			dval_n   = '0;
			brem_n   = '0;
			ccount_n = '0;
			sat_n    = 1'b0;
		end

		// clear overrides everything
		if (in_ch.clear_frame) begin
			mode_n   = MODE_START;
			dval_n   = '0;
			brem_n   = '0;
			cfield_n = '0;
			ccount_n = '0;
			sat_n    = 1'b0;
			kind     = cfft_pkg::KIND_CLEAR;
			res_val  = '0;
			res_len  = '0;
			res_ovf  = 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q  <= cfft_pkg::SEP_RESET;
			term_q <= cfft_pkg::TERM_RESET;
		end else if (cfg_wen) begin
			case (cfft_pkg::reg_idx_t'(cfg_index))
				cfft_pkg::REG_FIELD_SEPARATOR:  sep_q  <= cfg_wdata;
				cfft_pkg::REG_FRAME_TERMINATOR: term_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_START;
			dval_q   <= '0;
			brem_q   <= '0;
			cfield_q <= '0;
			ccount_q <= '0;
			sat_q    <= 1'b0;
		end else if (in_acc) begin
			mode_q   <= mode_n;
			dval_q   <= dval_n;
			brem_q   <= brem_n;
			cfield_q <= cfield_n;
			ccount_q <= ccount_n;
			sat_q    <= sat_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= in_acc || (out_valid_q && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			obyte_q <= in_ch.clear_frame ? 8'd0 : in_ch.data_byte;
			okind_q <= kind;
			oidx_q  <= in_ch.clear_frame ? 8'd0 : 8'(cfield_q);
			oval_q  <= 16'(res_val);
			olen_q  <= 16'(res_len);
			oovf_q  <= res_ovf;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_byte      = obyte_q;
	assign out_ch.byte_kind     = okind_q;
	assign out_ch.field_index   = oidx_q;
	assign out_ch.leading_value = oval_q;
	assign out_ch.field_length  = olen_q;
	assign out_ch.overflow_flag = oovf_q;

endmodule

// ----- sv/cfft_checker.sv -----
module cfft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_clear,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  out_kind,
	input logic [7:0]  out_index,
	input logic [15:0] out_length,
	input logic        out_ovf
);

	// empty output register never blocks intake
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// every accepted request yields a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request produced no result");

	// clear reports the reset field state
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_clear |=>
		out_kind == cfft_pkg::KIND_CLEAR && out_index == 8'd0 &&
		out_length == 16'd0 && !out_ovf)
		else $error("clear result not zeroed");

	// no kind code beyond clear
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_kind <= cfft_pkg::KIND_CLEAR)
		else $error("byte_kind out of range");

	// stalled result is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_length))
		else $error("stalled result changed");

endmodule

bind counted_field_frame_tokenizer_unit cfft_checker u_cfft_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_clear   (in_ch.clear_frame),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_kind   (out_ch.byte_kind),
	.out_index  (out_ch.field_index),
	.out_length (out_ch.field_length),
	.out_ovf    (out_ch.overflow_flag)
);
